// ----- src/line_end_converter_assert.svh -----
// ----------------------------------------------------------------------------
// line end converter assertion macros
// shared property wrappers, clocked on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef LINE_END_CONVERTER_ASSERT_SVH
`define LINE_END_CONVERTER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LEC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lec_pkg.sv -----
// ----------------------------------------------------------------------------
// lec_pkg
// shared constants and types of the line end converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lec_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // output line end selection, the spare code behaves as lf
  localparam logic [1:0] MODE_LF   = 2'd0;
  localparam logic [1:0] MODE_CRLF = 2'd1;
  localparam logic [1:0] MODE_CR   = 2'd2;

  // register indexes on the configuration port
  localparam logic REG_LINE_END_MODE = 1'b0;

  typedef enum logic [5:0] {
    ST_NORMAL        = 6'b000001,
    ST_CR_SEEN       = 6'b000010,
    ST_RUN_LF        = 6'b000100,
    ST_RUN_CR        = 6'b001000,
    ST_RUN_CRLF      = 6'b010000,
    ST_RUN_CRLF_HELD = 6'b100000
  } scan_state_t;

  // up to three bytes from one input, bytes[0] goes out first
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
  } result_t;

  typedef struct packed {
    scan_state_t scan_state;
    logic        held_is_cr;
  } scan_status_t;

endpackage

// ----- src/lec_cfg.sv -----
// ----------------------------------------------------------------------------
// lec_cfg
// apb register slave holding the output line end mode
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lec_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [1:0]  line_end_mode
);
  import lec_pkg::*;

  logic wr_mode;

  assign pready  = 1'b1;
  assign wr_mode = psel && penable && pwrite && (paddr[2] == REG_LINE_END_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_end_mode <= MODE_LF;
    end else if (wr_mode) begin
      line_end_mode <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LINE_END_MODE) begin
      prdata = {30'd0, line_end_mode};
    end
  end

endmodule

// ----- src/lec_step.sv -----
// ----------------------------------------------------------------------------
// lec_step
// scan state machine: turns one input byte into zero to three result bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lec_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_stream,
  input  logic [1:0]            line_end_mode,
  output lec_pkg::result_t      res,
  output lec_pkg::scan_status_t status
);
  import lec_pkg::*;

  scan_state_t scan_state, scan_state_next;
  logic        held_is_cr, held_is_cr_next;

  logic [1:0][7:0] eol_bytes;
  logic [1:0]      eol_cnt;
  logic [1:0][7:0] txt_bytes;
  logic [1:0]      txt_cnt;
  scan_state_t     txt_state;
  logic [7:0]      held_byte;
  logic            is_cr, is_lf;

  assign is_cr     = (data_byte == CH_CR);
  assign is_lf     = (data_byte == CH_LF);
  assign held_byte = held_is_cr ? CH_CR : CH_LF;

  // configured line end
  always_comb begin
    eol_bytes = {CH_LF, CH_LF};
    eol_cnt   = 2'd1;
    unique case (line_end_mode)
      MODE_CRLF: begin
        eol_bytes = {CH_LF, CH_CR};
        eol_cnt   = 2'd2;
      end
      MODE_CR: begin
        eol_bytes = {CH_CR, CH_CR};
      end
      default: begin
        eol_bytes = {CH_LF, CH_LF};
      end
    endcase
  end

  // plain text handling of the current byte
  always_comb begin
    if (is_lf) begin
      txt_bytes = eol_bytes;
      txt_cnt   = eol_cnt;
      txt_state = ST_RUN_LF;
    end else if (is_cr) begin
      txt_bytes = eol_bytes;
      txt_cnt   = eol_cnt;
      txt_state = ST_CR_SEEN;
    end else begin
      txt_bytes = {data_byte, data_byte};
      txt_cnt   = 2'd1;
      txt_state = ST_NORMAL;
    end
  end

  always_comb begin
    res             = '0;
    scan_state_next = scan_state;
    held_is_cr_next = held_is_cr;
    if (end_of_stream) begin
      // flush a held byte, a pending cr was already converted
      if (scan_state == ST_RUN_CRLF_HELD) begin
        res.bytes[0] = held_byte;
        res.cnt      = 2'd1;
      end
      scan_state_next = ST_NORMAL;
      held_is_cr_next = 1'b0;
    end else begin
      unique case (scan_state)
        ST_CR_SEEN: begin
          if (is_lf) begin
            scan_state_next = ST_RUN_CRLF;
          end else if (is_cr) begin
            res.bytes[1:0]  = eol_bytes;
            res.cnt         = eol_cnt;
            scan_state_next = ST_RUN_CR;
          end else begin
            res.bytes[0]    = data_byte;
            res.cnt         = 2'd1;
            scan_state_next = ST_NORMAL;
          end
        end
        ST_RUN_LF, ST_RUN_CR: begin
          if ((scan_state == ST_RUN_LF) ? is_lf : is_cr) begin
            res.bytes[1:0] = eol_bytes;
            res.cnt        = eol_cnt;
          end else begin
            // other line byte goes raw, ordinary byte ends the run
            res.bytes[0] = data_byte;
            res.cnt      = 2'd1;
            if (!is_cr && !is_lf) begin
              scan_state_next = ST_NORMAL;
            end
          end
        end
        ST_RUN_CRLF: begin
          if (is_cr || is_lf) begin
            held_is_cr_next = is_cr;
            scan_state_next = ST_RUN_CRLF_HELD;
          end else begin
            res.bytes[0]    = data_byte;
            res.cnt         = 2'd1;
            scan_state_next = ST_NORMAL;
          end
        end
        ST_RUN_CRLF_HELD: begin
          if (held_is_cr && is_lf) begin
            res.bytes[1:0]  = eol_bytes;
            res.cnt         = eol_cnt;
            scan_state_next = ST_RUN_CRLF;
          end else begin
            // broken crlf: held byte raw, then this byte as plain text
            res.bytes[0]    = held_byte;
            res.bytes[2:1]  = txt_bytes;
            res.cnt         = txt_cnt + 2'd1;
            scan_state_next = txt_state;
          end
          held_is_cr_next = 1'b0;
        end
        default: begin
          res.bytes[1:0]  = txt_bytes;
          res.cnt         = txt_cnt;
          scan_state_next = txt_state;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= ST_NORMAL;
      held_is_cr <= 1'b0;
    end else if (accept) begin
      scan_state <= scan_state_next;
      held_is_cr <= held_is_cr_next;
    end
  end

  assign status.scan_state = scan_state;
  assign status.held_is_cr = held_is_cr;

endmodule

// ----- src/lec_out_buf.sv -----
// ----------------------------------------------------------------------------
// lec_out_buf
// result register, shifts out one input's bytes one per cycle unless stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lec_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  lec_pkg::result_t res,
  input  logic             out_stall,
  output logic             can_load,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             last
);
  import lec_pkg::*;

  logic [2:0][7:0] bytes;
  logic [1:0]      cnt;
  logic            take;

  assign out_valid = (cnt != 2'd0);
  assign out_byte  = bytes[0];
  assign last      = (cnt == 2'd1);
  assign take      = out_valid && !out_stall;
  // free now, or the final byte leaves this cycle
  assign can_load  = (cnt == 2'd0) || (last && !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res.cnt;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= res.bytes;
    end else if (take) begin
      bytes <= {8'h00, bytes[2], bytes[1]};
    end
  end

endmodule

// ----- src/line_end_converter.sv -----
// ----------------------------------------------------------------------------
// line_end_converter
// rewrites lf, crlf and lone cr line ends of a byte stream as the configured
// line end, passing ordinary bytes through
// ----------------------------------------------------------------------------
//
//  channel  handshake                    payload
//  -------  ---------------------------  ---------------------------------
//  input    in_valid / in_stall          data_byte[7:0], end_of_stream
//  output   out_valid / out_stall        out_byte[7:0], last
//  config   apb psel/penable/pwrite      paddr[2:0], pwdata/prdata[31:0]
//
//  one input transaction per cycle while each input yields at most one byte and out_stall is low
//  an input yielding more bytes holds the input side until its last byte leaves the
//  single result register, which shifts out one byte a cycle unless stalled (0 to 3 bytes)
//  inputs that yield no byte are taken every cycle once the result register is free
//  synchronous reset returns the scan state to plain text and line_end_mode to lf,
//  in_stall is high while rst is high
//  out_stall only holds the result register; in_stall follows it combinationally
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_end_converter (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  // output byte stream
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lec_pkg::*;
  `include "line_end_converter_assert.svh"

  logic         [1:0] line_end_mode;
  logic               can_load;
  logic               in_take;
  logic               out_take;
  logic               scan_idle;
  logic               in_held;
  result_t            res;
  scan_status_t       status;

  // a new transaction is taken whenever the result register frees up
  assign in_stall = rst || !can_load;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  lec_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .line_end_mode (line_end_mode)
  );

  // combinational conversion of the incoming byte against the scan state
  lec_step u_step (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_take),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .line_end_mode (line_end_mode),
    .res           (res),
    .status        (status)
  );

  // result register and byte serializer
  lec_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_take),
    .res       (res),
    .out_stall (out_stall),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .last      (last)
  );

  assign scan_idle = (status.scan_state == ST_NORMAL) && !status.held_is_cr;
  assign in_held   = (status.scan_state == ST_RUN_CRLF_HELD);

  // a new input never overwrites bytes still waiting to go out
  `LEC_ASSERT_SAME(a_no_overwrite, in_take, !out_valid || (out_take && last), "bytes overwritten")
  // bytes of one input go out without gaps up to last
  `LEC_ASSERT_NEXT(a_burst_cont, out_take && !last, out_valid, "result burst broken before last")
  // end of stream always returns to plain text
  `LEC_ASSERT_NEXT(a_eos_clears, in_take && end_of_stream, scan_idle, "eos left scan state")
  // a held cr only exists in the held state of a crlf run
  `LEC_ASSERT_SAME(a_held_scope, status.held_is_cr, in_held, "held cr outside held state")

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for line_end_converter: a scoreboard class tracks the
// scan state and line end mode, predicts the output bytes of every accepted
// input transaction and compares them with the bytes that leave the block
// ----------------------------------------------------------------------------

// one expected output byte and its end-of-input marker
typedef struct packed {
  logic [7:0] value;
  logic       last;
} out_item_t;

class line_end_tracker;
  lec_pkg::scan_state_t state;
  logic                 held_cr;
  logic [1:0]           mode;
  out_item_t            expected_bytes[$];
  out_item_t            burst[$];
  int                   error_count;
  int                   accepted_items;
  int                   checked_bytes;
  int                   eos_items;

  function new();
    mode = lec_pkg::MODE_LF;
    error_count = 0;
    accepted_items = 0;
    checked_bytes = 0;
    eos_items = 0;
    clear_scan();
  endfunction

  function void clear_scan();
    state = lec_pkg::ST_NORMAL;
    held_cr = 1'b0;
  endfunction

  function void set_mode(logic [1:0] m);
    mode = m;
  endfunction

  function int pending();
    return expected_bytes.size();
  endfunction

  function void push_raw(logic [7:0] b);
    out_item_t it;
    it.value = b;
    it.last = 1'b0;
    burst.push_back(it);
  endfunction

  // configured line end, the spare mode code falls back to lf
  function void push_eol();
    case (mode)
      lec_pkg::MODE_CRLF: begin
        push_raw(lec_pkg::CH_CR);
        push_raw(lec_pkg::CH_LF);
      end
      lec_pkg::MODE_CR: push_raw(lec_pkg::CH_CR);
      default: push_raw(lec_pkg::CH_LF);
    endcase
  endfunction

  // byte seen in plain text
  function void plain_text_byte(logic [7:0] b);
    if (b == lec_pkg::CH_LF) begin
      state = lec_pkg::ST_RUN_LF;
      push_eol();
    end else if (b == lec_pkg::CH_CR) begin
      state = lec_pkg::ST_CR_SEEN;
      push_eol();
    end else begin
      state = lec_pkg::ST_NORMAL;
      push_raw(b);
    end
  endfunction

  function void predict_bytes(logic [7:0] b, logic eos);
    out_item_t  it;
    logic [7:0] kind;
    burst.delete();
    accepted_items++;
    if (eos) begin
      eos_items++;
      if (state == lec_pkg::ST_RUN_CRLF_HELD)
        push_raw(held_cr ? lec_pkg::CH_CR : lec_pkg::CH_LF);
      clear_scan();
    end else begin
      case (state)
        lec_pkg::ST_CR_SEEN: begin
          // cr already converted: lf completes crlf, another cr is a new line end
          if (b == lec_pkg::CH_LF) begin
            state = lec_pkg::ST_RUN_CRLF;
          end else if (b == lec_pkg::CH_CR) begin
            state = lec_pkg::ST_RUN_CR;
            push_eol();
          end else begin
            state = lec_pkg::ST_NORMAL;
            push_raw(b);
          end
        end
        lec_pkg::ST_RUN_LF, lec_pkg::ST_RUN_CR: begin
          kind = (state == lec_pkg::ST_RUN_LF) ? lec_pkg::CH_LF : lec_pkg::CH_CR;
          if (b == kind) begin
            push_eol();
          end else if (b == lec_pkg::CH_CR || b == lec_pkg::CH_LF) begin
            push_raw(b);
          end else begin
            state = lec_pkg::ST_NORMAL;
            push_raw(b);
          end
        end
        lec_pkg::ST_RUN_CRLF: begin
          if (b == lec_pkg::CH_CR || b == lec_pkg::CH_LF) begin
            held_cr = (b == lec_pkg::CH_CR);
            state = lec_pkg::ST_RUN_CRLF_HELD;
          end else begin
            state = lec_pkg::ST_NORMAL;
            push_raw(b);
          end
        end
        lec_pkg::ST_RUN_CRLF_HELD: begin
          if (held_cr && b == lec_pkg::CH_LF) begin
            state = lec_pkg::ST_RUN_CRLF;
            push_eol();
          end else begin
            // broken crlf: held byte goes out raw, then plain text handling
            push_raw(held_cr ? lec_pkg::CH_CR : lec_pkg::CH_LF);
            plain_text_byte(b);
          end
          held_cr = 1'b0;
        end
        default: plain_text_byte(b);
      endcase
    end
    if (burst.size() > 0) begin
      it = burst.pop_back();
      it.last = 1'b1;
      burst.push_back(it);
    end
    foreach (burst[i]) expected_bytes.push_back(burst[i]);
  endfunction

  task flag_mismatch(string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_out_byte(logic [7:0] b, logic l);
    out_item_t want;
    if (expected_bytes.size() == 0) begin
      flag_mismatch($sformatf("unexpected output byte %02h last %0b", b, l));
      return;
    end
    want = expected_bytes.pop_front();
    checked_bytes++;
    if (b !== want.value)
      flag_mismatch($sformatf("out_byte %02h, expected %02h", b, want.value));
    if (l !== want.last)
      flag_mismatch($sformatf("last %0b on byte %02h, expected %0b", l, b, want.last));
  endtask
endclass

module testbench;
  import lec_pkg::*;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         SETTLE       = 10;    // idle cycles around register writes
  localparam int         DRAIN_LIMIT  = 5000;
  localparam int         PHASE_ITEMS  = 25;
  localparam int         PHASES       = 5;
  localparam int         GAP_MAX      = 12;
  localparam logic [1:0] MODE_SPARE   = 2'd3;  // unused code, behaves as lf

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        end_of_stream;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  line_end_tracker tracker;
  bit              in_burst;   // phase with no gaps on the input side
  bit              out_burst;  // phase with no stalls on the output side
  int              cycle_count;

  line_end_converter dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .last          (last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit, far above the slowest legal run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // output side: draw a stall length per byte, then take one transaction
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      n = out_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // output monitor, every accepted byte is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_out_byte(out_byte, last);
  end

  // one input transaction, called at a falling edge, returns at a falling edge
  task send_byte(logic [7:0] b, logic eos);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid = 1'b0;
      data_byte = 8'($urandom_range(0, 255));
      end_of_stream = 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    data_byte = b;
    end_of_stream = eos;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    tracker.predict_bytes(b, eos);
    @(negedge clk);
  endtask

  // wait until every predicted byte came out, then let the pipe settle
  task wait_drained();
    int waited;
    in_valid = 1'b0;
    waited = 0;
    while (tracker.pending() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // apb write of line_end_mode followed by a read back
  task write_line_end_mode(logic [1:0] m);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {REG_LINE_END_MODE, 2'b00};
    pwdata = 32'(m);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_mode(m);
    @(negedge clk);
    // read setup right after the write
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[1:0] !== m)
      tracker.flag_mismatch($sformatf("line_end_mode reads %0d, wrote %0d", prdata[1:0], m));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    repeat (SETTLE) @(negedge clk);
  endtask

  // random item, mostly line ends and text so runs and crlf pairs form often
  function automatic logic [8:0] draw_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return {1'b0, CH_CR};
    if (pick < 55) return {1'b0, CH_LF};
    if (pick < 88) return {1'b0, 8'($urandom_range(8'h20, 8'h7e))};
    if (pick < 95) return {1'b0, 8'($urandom_range(0, 255))};
    return {1'b1, 8'($urandom_range(0, 255))};
  endfunction

  initial begin
    logic [8:0] directed[$];
    logic [8:0] item;
    logic [1:0] phase_mode[PHASES];

    tracker = new();
    in_burst = 1'b0;
    out_burst = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    end_of_stream = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part under the reset mode: byte extremes, lf and cr runs, raw
    // line ends inside a run, cr after lone cr, crlf run, broken crlf, and end
    // of stream with a held byte or a pending cr
    directed = '{
      {1'b0, 8'h00}, {1'b0, 8'hff}, {1'b0, CH_LF}, {1'b0, CH_LF},
      {1'b0, CH_CR}, {1'b0, 8'h61}, {1'b0, CH_CR}, {1'b0, CH_CR},
      {1'b0, CH_LF}, {1'b0, 8'h62}, {1'b0, CH_CR}, {1'b0, CH_LF},
      {1'b0, CH_CR}, {1'b0, CH_LF}, {1'b0, CH_CR}, {1'b0, 8'h63},
      {1'b0, CH_CR}, {1'b0, CH_LF}, {1'b0, CH_LF}, {1'b1, 8'hff},
      {1'b0, CH_CR}, {1'b1, 8'h00}, {1'b0, 8'h64}, {1'b1, 8'h5a}
    };
    @(negedge clk);
    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    wait_drained();

    // random phases, each under its own line end setting
    phase_mode = '{MODE_CRLF, MODE_CR, MODE_SPARE, MODE_LF,
                   2'($urandom_range(0, 3))};
    for (int p = 0; p < PHASES; p++) begin
      write_line_end_mode(phase_mode[p]);
      in_burst = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        item = draw_item();
        send_byte(item[7:0], item[8]);
      end
      wait_drained();
    end

    if (tracker.pending() > 0)
      tracker.flag_mismatch($sformatf("%0d expected bytes never arrived", tracker.pending()));

    $display("covered %0d input transactions (%0d end of stream), %0d output bytes",
             tracker.accepted_items, tracker.eos_items, tracker.checked_bytes);
    $display("line end modes lf, crlf, cr and the spare code, with random gaps and stalls");
    if (tracker.error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
